// File: design/lsp_pkg.sv
// Shared types and constants for the log sense parameter extractor.
// No dependencies; imported by every module of the block.
package lsp_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int OUT_VALUE_W     = 64;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int FIFO_DEPTH      = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_PARAM = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_SHIFT  = 2'd1;

  localparam logic [1:0] PH_PAGE_HDR  = 2'd0;
  localparam logic [1:0] PH_PARAM_HDR = 2'd1;
  localparam logic [1:0] PH_VALUE     = 2'd2;
  localparam logic [1:0] PH_DONE      = 2'd3;

  localparam logic KIND_PARAM    = 1'b0;
  localparam logic KIND_PAGE_END = 1'b1;

  typedef struct packed {
    logic [7:0] page_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic                   kind;
    logic [OUT_VALUE_W-1:0] scaled_value;
    logic                   overflow;
    logic                   truncated;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] target_param;
    logic [3:0]  scale_shift;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  r0;
    out_item_t  r1;
  } push_t;

endpackage

// File: design/log_sense_param_extractor.sv
// Top level: input register, config registers, parser and result queue.
// Depends on lsp_pkg, lsp_parser, lsp_out_fifo.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | in_data  (in_item_t)
//  out_    | output    | out_valid / out_stall| out_data (out_item_t)
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One byte per cycle sustained while in_stall is low; a byte giving two results leaves both
// in the 4-entry result queue, which the single-item output port drains one at a time.
// A result reaches out_data through the input register, the parser and the result queue.
// Synchronous active-low reset clears parser state, config, and queue.
// in_stall rises when the input register holds a byte and the queue lacks room for two.
module log_sense_param_extractor
  import lsp_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  in_item_t in_r;
  logic     in_v_r, in_v_nxt;
  cfg_t     cfg_r;
  push_t    push;
  logic     room2, go, accept;

  assign cfg_ready = 1'b1;
  assign go        = in_v_r && room2;
  assign in_stall  = in_v_r && !room2;
  assign accept    = in_valid && !in_stall;
  assign in_v_nxt  = accept ? 1'b1 : (go ? 1'b0 : in_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      cfg_r  <= '0;
    end else begin
      in_v_r <= in_v_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TARGET_PARAM: cfg_r.target_param <= cfg_data;
          CFG_SCALE_SHIFT:  cfg_r.scale_shift  <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_r <= in_data;
  end

  lsp_parser #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_parser (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (go),
    .item (in_r),
    .cfg  (cfg_r),
    .push (push)
  );

  lsp_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room2    (room2),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// File: design/lsp_parser.sv
// Page parser: header, parameter and value tracking, value rounding.
// Depends on lsp_pkg; emits up to two result items per byte.
module lsp_parser
  import lsp_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     go,
  input  in_item_t item,
  input  cfg_t     cfg,
  output push_t    push
);

  localparam logic [VALUE_WIDTH-1:0] ONE = {{(VALUE_WIDTH-1){1'b0}}, 1'b1};

  logic [1:0]             phase_r, phase_nxt;
  logic [16:0]            bpos_r, bpos_nxt;
  logic [15:0]            plen_r, plen_nxt;
  logic [15:0]            pcode_r, pcode_nxt;
  logic [7:0]             prlen_r, prlen_nxt;
  logic [7:0]             pseen_r, pseen_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic                   sat_r, sat_nxt;

  logic [16:0]            bpos_inc;
  logic [7:0]             pseen_inc;
  logic                   fin;
  logic [VALUE_WIDTH-1:0] q, t;
  logic [3:0]             sm1;
  logic                   gbit, sticky, up;
  logic [OUT_VALUE_W-1:0] val64;
  out_item_t              pres, eres;

  always_comb begin
    phase_nxt = phase_r;
    bpos_nxt  = bpos_r;
    plen_nxt  = plen_r;
    pcode_nxt = pcode_r;
    prlen_nxt = prlen_r;
    pseen_nxt = pseen_r;
    acc_nxt   = acc_r;
    sat_nxt   = sat_r;
    fin       = 1'b0;
    pseen_inc = pseen_r + 8'd1;

    bpos_inc = (phase_r != PH_DONE && bpos_r != 17'h1FFFF) ? bpos_r + 17'd1 : bpos_r;
    bpos_nxt = bpos_inc;

    case (phase_r)
      PH_PAGE_HDR: begin
        if (bpos_inc == 17'd3) plen_nxt[15:8] = item.page_byte;
        else if (bpos_inc == 17'd4) plen_nxt[7:0] = item.page_byte;
        if (bpos_inc >= 17'd4) begin
          pseen_nxt = '0;
          phase_nxt = (plen_nxt == 16'd0) ? PH_DONE : PH_PARAM_HDR;
        end
      end
      PH_PARAM_HDR: begin
        if (pseen_r == 8'd0) pcode_nxt[15:8] = item.page_byte;
        else if (pseen_r == 8'd1) pcode_nxt[7:0] = item.page_byte;
        else if (pseen_r == 8'd3) prlen_nxt = item.page_byte;
        pseen_nxt = pseen_inc;
        if (pseen_inc >= 8'd4) begin
          pseen_nxt = '0;
          acc_nxt   = '0;
          sat_nxt   = 1'b0;
          if (prlen_nxt == 8'd0) fin = 1'b1;
          else phase_nxt = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (sat_r || acc_r[VALUE_WIDTH-1 -: 8] != 8'd0) begin
          acc_nxt = '1;
          sat_nxt = 1'b1;
        end else begin
          acc_nxt = {acc_r[VALUE_WIDTH-9:0], item.page_byte};
        end
        pseen_nxt = pseen_inc;
        if (pseen_inc >= prlen_r) fin = 1'b1;
      end
      default: ;
    endcase

    if (fin) begin
      pseen_nxt = '0;
      phase_nxt = (bpos_inc >= 17'd4 + {1'b0, plen_r}) ? PH_DONE : PH_PARAM_HDR;
    end
  end

  // round half to even on the finished value
  always_comb begin
    sm1    = cfg.scale_shift - 4'd1;
    q      = acc_nxt >> cfg.scale_shift;
    t      = acc_nxt >> sm1;
    gbit   = t[0];
    sticky = |(acc_nxt & ((ONE << sm1) - ONE));
    up     = (cfg.scale_shift != 4'd0) && gbit && (sticky || q[0]);
    val64  = '0;
    val64[VALUE_WIDTH-1:0] = q + (up ? ONE : '0);
  end

  always_comb begin
    pres.kind         = KIND_PARAM;
    pres.scaled_value = val64;
    pres.overflow     = sat_nxt;
    pres.truncated    = 1'b0;
    pres.last         = !item.end_of_buffer;
    eres.kind         = KIND_PAGE_END;
    eres.scaled_value = '0;
    eres.overflow     = 1'b0;
    eres.truncated    = (phase_nxt != PH_DONE);
    eres.last         = 1'b1;

    push.cnt = 2'd0;
    push.r0  = eres;
    push.r1  = eres;
    if (go) begin
      if (fin && pcode_nxt == cfg.target_param) begin
        push.r0  = pres;
        push.cnt = item.end_of_buffer ? 2'd2 : 2'd1;
      end else if (item.end_of_buffer) begin
        push.cnt = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (go && item.end_of_buffer)) begin
      phase_r <= PH_PAGE_HDR;
      bpos_r  <= '0;
      plen_r  <= '0;
      pcode_r <= '0;
      prlen_r <= '0;
      pseen_r <= '0;
      acc_r   <= '0;
      sat_r   <= 1'b0;
    end else if (go) begin
      phase_r <= phase_nxt;
      bpos_r  <= bpos_nxt;
      plen_r  <= plen_nxt;
      pcode_r <= pcode_nxt;
      prlen_r <= prlen_nxt;
      pseen_r <= pseen_nxt;
      acc_r   <= acc_nxt;
      sat_r   <= sat_nxt;
    end
  end

`ifndef SYNTH
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd2) |-> (push.r0.kind == KIND_PARAM && push.r1.kind == KIND_PAGE_END
                            && !push.r0.last && push.r1.last))
    else $error("two results out of order");
  a_eob_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (go && item.end_of_buffer) |=> (phase_r == PH_PAGE_HDR && bpos_r == 17'd0))
    else $error("parser did not restart after end of buffer");
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE && !(go && item.end_of_buffer)) |=> $stable(bpos_r))
    else $error("byte position moved after page end");
`endif

endmodule

// File: design/lsp_out_fifo.sv
// Result queue: takes up to two items a cycle, gives one a cycle while out_stall is low.
// Depends on lsp_pkg.
module lsp_out_fifo
  import lsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  push_t     push,
  output logic      room2,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  out_item_t        mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp1;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rp_r];
  assign room2     = (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign pop       = out_valid && !out_stall;
  assign wp1       = wp_r + PTR_W'(1);

  always_comb begin
    wp_nxt  = wp_r + PTR_W'(push.cnt);
    rp_nxt  = pop ? rp_r + PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + CNT_W'(push.cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wp_r] <= push.r0;
    if (push.cnt == 2'd2) mem[wp1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue count above depth");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> ((CNT_W + 1)'(cnt_r) + (CNT_W + 1)'(push.cnt)
                            <= (CNT_W + 1)'(FIFO_DEPTH)))
    else $error("result queue overrun");
  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push.cnt == 2'd0) |=> (cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("result queue count did not drop on pop");
`endif

endmodule
